FILE: sv/rrjs_pkg.sv
// ----------------------------------------------------------------------------
// rrjs_pkg
// Shared types, codes and helpers of the round-robin job scheduler.
// ----------------------------------------------------------------------------
package rrjs_pkg;

  // queue geometry
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int unsigned ID_W    = 8;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned ENTRY_W = ID_W + TIME_W;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_IDX_QUANTUM = 1'b0;
  localparam logic [TIME_W-1:0] QUANTUM_RESET = TIME_W'(4);

  // input item kind
  typedef enum logic {
    CMD_ADD      = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_e;

  // result status
  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_SLICE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture input beat and read head entry
    logic exec;   // update queue and load output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a new result
  } dp_stat_t;

  // circular pointer advance
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

FILE: sv/rrjs_ctrl.sv
// ----------------------------------------------------------------------------
// rrjs_ctrl
// Sequencer: takes one input beat, then retires it into the output register.
// ----------------------------------------------------------------------------
module rrjs_ctrl
  import rrjs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/rrjs_dpath.sv
// ----------------------------------------------------------------------------
// rrjs_dpath
// Job queue memory, pointers, slice arithmetic and output register.
// ----------------------------------------------------------------------------
module rrjs_dpath
  import rrjs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  logic              in_cmd_i,
  input  logic [ID_W-1:0]   in_job_id_i,
  input  logic [TIME_W-1:0] in_run_time_i,
  input  logic [TIME_W-1:0] quantum_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        out_status_o,
  output logic [ID_W-1:0]   out_slice_job_o,
  output logic [TIME_W-1:0] out_slice_time_o,
  output logic              out_finished_o
);

  logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  logic               cmd_q;
  logic [ID_W-1:0]    id_q;
  logic [TIME_W-1:0]  rt_q;

  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [OCC_W-1:0]   occ_q, occ_d;

  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [ID_W-1:0]    sjob_q, sjob_d;
  logic [TIME_W-1:0]  stime_q, stime_d;
  logic               fin_q, fin_d;

  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic               q_full;
  logic               q_empty;
  logic [ID_W-1:0]    hd_id;
  logic [TIME_W-1:0]  hd_time;

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // input capture and head read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;
      id_q  <= in_job_id_i;
      rt_q  <= in_run_time_i;
      rd_q  <= mem_q[head_q];
    end
  end

  // queue memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= wr_data;
    end
  end

  assign q_full  = (occ_q == OCC_W'(QUEUE_DEPTH));
  assign q_empty = (occ_q == '0);
  assign hd_id   = rd_q[ID_W-1:0];
  assign hd_time = rd_q[ENTRY_W-1:ID_W];

  // queue update and result
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    wr_en    = 1'b0;
    wr_data  = {rt_q, id_q};
    status_d = ST_ADDED;
    sjob_d   = '0;
    stime_d  = '0;
    fin_d    = 1'b0;
    case (cmd_e'(cmd_q))
      CMD_ADD: begin
        if (q_full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_ADDED;
          wr_en    = 1'b1;
          tail_d   = next_ptr(tail_q);
          occ_d    = occ_q + OCC_W'(1);
        end
      end
      CMD_DISPATCH: begin
        if (q_empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_SLICE;
          sjob_d   = hd_id;
          head_d   = next_ptr(head_q);
          if (hd_time > quantum_i) begin
            // unfinished job goes back to the tail
            stime_d = quantum_i;
            wr_en   = 1'b1;
            wr_data = {hd_time - quantum_i, hd_id};
            tail_d  = next_ptr(tail_q);
          end else begin
            stime_d = hd_time;
            fin_d   = 1'b1;
            occ_d   = occ_q - OCC_W'(1);
          end
        end
      end
      default: begin
        status_d = ST_ADDED;
      end
    endcase
    if (!cmd_i.exec) begin
      head_d = head_q;
      tail_d = tail_q;
      occ_d  = occ_q;
      wr_en  = 1'b0;
    end
  end

  // pointer and occupancy registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  // output register valid
  always_comb begin
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      sjob_q   <= sjob_d;
      stime_q  <= stime_d;
      fin_q    <= fin_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = status_q;
  assign out_slice_job_o  = sjob_q;
  assign out_slice_time_o = stime_q;
  assign out_finished_o   = fin_q;

endmodule

FILE: sv/round_robin_job_scheduler.sv
// A beat is captured at its accepting edge and its result is loaded into the
// output register, raising m_axis_tvalid, once that register is free.
// Each beat takes an accept step with the queue memory read, then a queue
// update step; the next beat is taken while a result waits downstream.
// Reset: rst_ni clears queue pointers, occupancy, control state and sets the
// quantum to 4; queue memory contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// round_robin_job_scheduler
// Round-robin time-slice scheduler over a circular job queue.
// ----------------------------------------------------------------------------
module round_robin_job_scheduler
  import rrjs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // [7:0] job_id, [23:8] run_time
  input  logic [0:0]         s_axis_tuser,   // [0] cmd
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [7:0] slice_job, [23:8] slice_time,
                                             // [24] finished, [31:25] zero
  output logic [1:0]         m_axis_tuser,   // [1:0] status
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ctrl_cmd_t         ctrl_cmd;
  dp_stat_t          dp_stat;
  logic [TIME_W-1:0] quantum_q;
  logic              reg_sel;
  logic [ID_W-1:0]   slice_job;
  logic [TIME_W-1:0] slice_time;
  logic              finished;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_IDX_QUANTUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      quantum_q <= pwdata[TIME_W-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(quantum_q) : '0;

  rrjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  rrjs_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .stat_o           (dp_stat),
    .in_cmd_i         (s_axis_tuser[0]),
    .in_job_id_i      (s_axis_tdata[ID_W-1:0]),
    .in_run_time_i    (s_axis_tdata[ENTRY_W-1:ID_W]),
    .quantum_i        (quantum_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_status_o     (m_axis_tuser),
    .out_slice_job_o  (slice_job),
    .out_slice_time_o (slice_time),
    .out_finished_o   (finished)
  );

  // pack result beat
  assign m_axis_tdata = {7'd0, finished, slice_time, slice_job};

endmodule

FILE: sv/rrjs_checker.sv
// ----------------------------------------------------------------------------
// rrjs_checker
// Port-level checks of the scheduler result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rrjs_checker
  import rrjs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // add and full results carry no slice
  a_add_no_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_ADDED || m_axis_tuser == ST_FULL)
      |-> m_axis_tdata == 32'd0)
    else $error("add result with slice fields set");

  // empty results carry no slice
  a_empty_no_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata == 32'd0)
    else $error("empty result with slice fields set");

  // finish only on slice
  a_fin_on_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tuser == ST_SLICE)
    else $error("finished flag without slice status");

endmodule

bind round_robin_job_scheduler rrjs_checker u_rrjs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/rrjs_schedule_checker.sv
// ----------------------------------------------------------------------------
// rrjs_schedule_checker
// Watches the job and result streams and the register port of the scheduler,
// keeps its own copy of the job queue and quantum, and compares every result
// beat with the oldest predicted slice.
// ----------------------------------------------------------------------------
module rrjs_schedule_checker
  import rrjs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // job stream
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [23:0]        s_tdata_i,    // [7:0] job_id, [23:8] run_time
  input  logic [0:0]         s_tuser_i,    // [0] cmd
  // result stream
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [31:0]        m_tdata_i,    // [7:0] slice_job, [23:8] slice_time,
                                           // [24] finished, [31:25] zero
  input  logic [1:0]         m_tuser_i,    // [1:0] status
  // register port
  input  logic               cfg_sel_i,
  input  logic               cfg_enable_i,
  input  logic               cfg_write_i,
  input  logic               cfg_ready_i,
  input  logic [PADDR_W-1:0] cfg_addr_i,
  input  logic [PDATA_W-1:0] cfg_wdata_i,
  // totals for the testbench top
  output int unsigned        errors_o,
  output int unsigned        outstanding_o,
  output int unsigned        added_o,
  output int unsigned        full_o,
  output int unsigned        slices_o,
  output int unsigned        finished_o,
  output int unsigned        empty_o
);

  localparam logic [PADDR_W-1:0] QUANTUM_ADDR = {REG_IDX_QUANTUM, 2'b00};

  // one predicted result beat
  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     job;
    logic [TIME_W-1:0]   slice;
    logic                finished;
  } slice_result_t;

  // shadow of the job queue and the quantum register
  logic [ID_W-1:0]   job_ids   [QUEUE_DEPTH];
  logic [TIME_W-1:0] job_times [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_slot;
  logic [PTR_W-1:0]  tail_slot;
  logic [OCC_W-1:0]  queued;
  logic [TIME_W-1:0] quantum;

  slice_result_t expected_slices[$];
  slice_result_t oldest;

  int unsigned errors = 0;
  int unsigned added = 0;
  int unsigned full_hits = 0;
  int unsigned slices = 0;
  int unsigned finished = 0;
  int unsigned empties = 0;

  assign errors_o   = errors;
  assign added_o    = added;
  assign full_o     = full_hits;
  assign slices_o   = slices;
  assign finished_o = finished;
  assign empty_o    = empties;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    errors++;
  endtask

  function automatic logic [PTR_W-1:0] slot_after(input logic [PTR_W-1:0] slot);
    logic [PTR_W-1:0] res;
    res = (slot == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
    return res;
  endfunction

  function automatic void append_job(input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] left);
    job_ids[tail_slot]   = id;
    job_times[tail_slot] = left;
    tail_slot = slot_after(tail_slot);
    queued    = queued + 1'b1;
  endfunction

  // apply one job beat to the shadow queue and return the slice it yields
  function automatic slice_result_t schedule_job(input cmd_e cmd,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [TIME_W-1:0] run_time);
    slice_result_t res;
    logic [ID_W-1:0]   head_id;
    logic [TIME_W-1:0] head_left;
    res.status   = ST_ADDED;
    res.job      = '0;
    res.slice    = '0;
    res.finished = 1'b0;
    if (cmd == CMD_ADD) begin
      if (queued == OCC_W'(QUEUE_DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        append_job(id, run_time);
      end
    end else if (queued == '0) begin
      res.status = ST_EMPTY;
    end else begin
      head_id   = job_ids[head_slot];
      head_left = job_times[head_slot];
      head_slot = slot_after(head_slot);
      queued    = queued - 1'b1;
      res.status = ST_SLICE;
      res.job    = head_id;
      // a job with time left over goes back to the tail
      if (head_left > quantum) begin
        res.slice = quantum;
        append_job(head_id, head_left - quantum);
      end else begin
        res.slice    = head_left;
        res.finished = 1'b1;
      end
    end
    return res;
  endfunction

  // track config writes, predict on job beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_slot = '0;
      tail_slot = '0;
      queued    = '0;
      quantum   = QUANTUM_RESET;
      expected_slices.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_sel_i && cfg_enable_i && cfg_write_i && cfg_ready_i &&
          cfg_addr_i == QUANTUM_ADDR) begin
        quantum = cfg_wdata_i[TIME_W-1:0];
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_slices.push_back(schedule_job(cmd_e'(s_tuser_i[0]),
                                               s_tdata_i[7:0], s_tdata_i[23:8]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_slices.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", '0, m_tdata_i);
        end else begin
          oldest = expected_slices.pop_front();
          if (m_tuser_i != oldest.status)
            report_mismatch("status", oldest.status, m_tuser_i);
          if (m_tdata_i[7:0] != oldest.job)
            report_mismatch("slice_job", oldest.job, m_tdata_i[7:0]);
          if (m_tdata_i[23:8] != oldest.slice)
            report_mismatch("slice_time", oldest.slice, m_tdata_i[23:8]);
          if (m_tdata_i[24] != oldest.finished)
            report_mismatch("finished", oldest.finished, m_tdata_i[24]);
          if (m_tdata_i[31:25] != '0)
            report_mismatch("tdata padding", '0, m_tdata_i[31:25]);
          case (oldest.status)
            ST_ADDED: added++;
            ST_FULL:  full_hits++;
            ST_SLICE: begin
              slices++;
              if (oldest.finished) finished++;
            end
            default:  empties++;
          endcase
        end
      end
      outstanding_o <= expected_slices.size();
    end
  end

endmodule

FILE: tb/tb_round_robin_job_scheduler.sv
// ----------------------------------------------------------------------------
// tb_round_robin_job_scheduler
// Drives add and dispatch beats into the scheduler in random bursts while the
// result side stalls on its own pattern. A short directed opening hits the
// field extremes and the slice corner cases, then random phases under several
// quantum settings fill the queue to overflow, drain it to empty and wrap it.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_round_robin_job_scheduler;
  import rrjs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [PADDR_W-1:0] QUANTUM_ADDR = {REG_IDX_QUANTUM, 2'b00};

  typedef enum logic [1:0] {
    RX_OPEN  = 2'd0,
    RX_COIN  = 2'd1,
    RX_CHOKE = 2'd2
  } rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata = '0;   // [7:0] job_id, [23:8] run_time
  logic [0:0]         s_axis_tuser = '0;   // [0] cmd
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;        // [7:0] slice_job, [23:8] slice_time,
                                           // [24] finished, [31:25] zero
  logic [1:0]         m_axis_tuser;        // [1:0] status
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned added;
  int unsigned full_hits;
  int unsigned slices;
  int unsigned finished;
  int unsigned empties;

  int unsigned cycle_cnt = 0;
  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  round_robin_job_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  rrjs_schedule_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .cfg_sel_i     (psel),
    .cfg_enable_i  (penable),
    .cfg_write_i   (pwrite),
    .cfg_ready_i   (pready),
    .cfg_addr_i    (paddr),
    .cfg_wdata_i   (pwdata),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .added_o       (added),
    .full_o        (full_hits),
    .slices_o      (slices),
    .finished_o    (finished),
    .empty_o       (empties)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               outstanding);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side backpressure, mode changes after a random run length
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  m_axis_tready <= 1'b1;
      RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
      default:  m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // send one beat, then either continue the burst or idle for a while
  task automatic issue_beat(input cmd_e cmd, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] run_time);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {run_time, id};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // hold the sender until every result beat has come back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_quantum(input logic [TIME_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= QUANTUM_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly short jobs so the queue keeps draining, some extremes
  function automatic logic [TIME_W-1:0] pick_run_time();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0:       return '0;
      1:       return '1;
      2:       return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(0, 24));
    endcase
  endfunction

  // one phase of random traffic under a fixed quantum
  task automatic run_phase(input logic [TIME_W-1:0] quantum, input int unsigned add_pct,
                           input int unsigned count, input bit hold_midway);
    int unsigned n;
    wait_for_results();
    write_quantum(quantum);
    for (n = 0; n < count; n++) begin
      if (hold_midway && n == count / 2) wait_for_results();
      if ($urandom_range(1, 100) <= add_pct) begin
        issue_beat(CMD_ADD, ID_W'($urandom), pick_run_time());
      end else begin
        issue_beat(CMD_DISPATCH, ID_W'($urandom), TIME_W'($urandom));
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening under the reset quantum of 4
    issue_beat(CMD_DISPATCH, '1, '1);         // dispatch on an empty queue
    issue_beat(CMD_ADD, 8'h00, 16'h0000);     // zero run time
    issue_beat(CMD_ADD, 8'hFF, 16'hFFFF);     // longest job, gets requeued
    issue_beat(CMD_ADD, 8'hA5, 16'h0004);     // exactly one quantum
    issue_beat(CMD_ADD, 8'h5A, 16'h0005);     // one quantum plus one
    issue_beat(CMD_ADD, 8'h3C, 16'h0003);     // under one quantum
    issue_beat(CMD_DISPATCH, '0, '0);         // zero time job finishes with slice 0
    issue_beat(CMD_DISPATCH, 8'h12, 16'h3456);
    issue_beat(CMD_DISPATCH, 8'h12, 16'h3456);
    issue_beat(CMD_DISPATCH, 8'h12, 16'h3456);
    issue_beat(CMD_DISPATCH, 8'h12, 16'h3456);
    issue_beat(CMD_DISPATCH, 8'h12, 16'h3456); // requeued long job again
    issue_beat(CMD_DISPATCH, 8'h12, 16'h3456); // remainder of one finishes
    issue_beat(CMD_ADD, 8'h81, 16'h8000);
    issue_beat(CMD_ADD, 8'h7E, 16'h7FFF);

    // fill past full, then clear everything with the largest quantum
    run_phase(16'd1,     100, 72,  1'b0);
    run_phase(16'hFFFF,  10,  90,  1'b0);
    // zero quantum: jobs with time left cycle without progress
    run_phase(16'd0,     50,  110, 1'b0);
    run_phase(TIME_W'($urandom), 50, 110, 1'b0);
    run_phase(TIME_W'($urandom_range(1, 16)), 70, 110, 1'b0);
    run_phase(TIME_W'($urandom_range(1, 16)), 30, 110, 1'b0);
    run_phase(16'd2,     55,  110, 1'b0);
    run_phase(16'hFFFF,  20,  60,  1'b0);
    run_phase(QUANTUM_RESET, 50, 110, 1'b1);

    wait_for_results();
    repeat (8) @(posedge clk_i);

    $display("covered %0d beats in %0d cycles, quantum 0, 1, 2, 4, 65535 and random",
             beats_sent, cycle_cnt);
    $display("results: %0d added, %0d full, %0d slices (%0d finished), %0d empty",
             added, full_hits, slices, finished, empties);
    if (errors == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
